FILE: hw/rtl/rohc_crc3_crc7_crc8_check_core_assert.svh
// ----------------------------------------------------------------------------
// rohc crc check assertion macros
// shared concurrent assertion helpers, compiled out with ASSERT_OFF
// ----------------------------------------------------------------------------
`ifndef ROHC_CRC3_CRC7_CRC8_CHECK_CORE_ASSERT_SVH
`define ROHC_CRC3_CRC7_CRC8_CHECK_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// expression holds on every clock edge out of reset
`define RCRC_ASSERT(name, clk, rst_n, expr) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define RCRC_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define RCRC_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define RCRC_ASSERT(name, clk, rst_n, expr)
`define RCRC_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define RCRC_ASSERT_NXT(name, clk, rst_n, ante, cons)

`endif

`endif

FILE: hw/rtl/rcrc_pkg.sv
// ----------------------------------------------------------------------------
// rcrc_pkg
// types and constants shared by the rohc crc-3/7/8 check block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rcrc_pkg;

  localparam int unsigned CrcW  = 8;
  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;

  // crc kind codes carried with each byte
  typedef enum logic [1:0] {
    KIND_CRC8    = 2'd0,
    KIND_CRC7    = 2'd1,
    KIND_CRC3    = 2'd2,
    KIND_UNKNOWN = 2'd3
  } kind_e;

  // register indexes, byte address is 4 * index
  localparam logic [2:0] REG_POLY_THREE = 3'd0;
  localparam logic [2:0] REG_POLY_SEVEN = 3'd1;
  localparam logic [2:0] REG_POLY_EIGHT = 3'd2;
  localparam logic [2:0] REG_INIT_THREE = 3'd3;
  localparam logic [2:0] REG_INIT_SEVEN = 3'd4;
  localparam logic [2:0] REG_INIT_EIGHT = 3'd5;

  // reset values
  localparam logic [2:0] POLY_THREE_RST = 3'd6;
  localparam logic [6:0] POLY_SEVEN_RST = 7'd121;
  localparam logic [7:0] POLY_EIGHT_RST = 8'd224;
  localparam logic [2:0] INIT_THREE_RST = 3'd7;
  localparam logic [6:0] INIT_SEVEN_RST = 7'd127;
  localparam logic [7:0] INIT_EIGHT_RST = 8'd255;

  // width masks per kind
  localparam logic [CrcW-1:0] MASK_EIGHT = 8'hff;
  localparam logic [CrcW-1:0] MASK_SEVEN = 8'h7f;
  localparam logic [CrcW-1:0] MASK_THREE = 8'h07;
  localparam logic [CrcW-1:0] MASK_NONE  = 8'h00;

  // configuration register set
  typedef struct packed {
    logic [2:0] poly_three;
    logic [6:0] poly_seven;
    logic [7:0] poly_eight;
    logic [2:0] init_three;
    logic [6:0] init_seven;
    logic [7:0] init_eight;
  } cfg_t;

  // classified byte waiting for the crc engine
  typedef struct packed {
    logic [7:0]      data;
    logic            first;
    logic            last;
    logic [7:0]      expected;
    logic [CrcW-1:0] poly;
    logic [CrcW-1:0] init;
    logic [CrcW-1:0] mask;
  } entry_t;

endpackage

FILE: hw/rtl/rcrc_front.sv
// ----------------------------------------------------------------------------
// rcrc_front
// input handshake and kind decode into a queue entry
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rcrc_front (
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            kind_i,
  input  logic [7:0]            data_byte_i,
  input  logic                  first_byte_i,
  input  logic                  last_byte_i,
  input  logic [7:0]            expected_crc_i,
  input  rcrc_pkg::cfg_t        cfg_i,
  input  logic                  full_i,
  output logic                  push_o,
  output rcrc_pkg::entry_t      entry_o
);

  rcrc_pkg::kind_e kind;

  assign kind       = rcrc_pkg::kind_e'(kind_i);
  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  // pick polynomial, seed and width for the kind
  always_comb begin
    entry_o.data     = data_byte_i;
    entry_o.first    = first_byte_i;
    entry_o.last     = last_byte_i;
    entry_o.expected = expected_crc_i;
    case (kind)
      rcrc_pkg::KIND_CRC8: begin
        entry_o.poly = cfg_i.poly_eight;
        entry_o.init = cfg_i.init_eight;
        entry_o.mask = rcrc_pkg::MASK_EIGHT;
      end
      rcrc_pkg::KIND_CRC7: begin
        entry_o.poly = {1'b0, cfg_i.poly_seven};
        entry_o.init = {1'b0, cfg_i.init_seven};
        entry_o.mask = rcrc_pkg::MASK_SEVEN;
      end
      rcrc_pkg::KIND_CRC3: begin
        entry_o.poly = {5'd0, cfg_i.poly_three};
        entry_o.init = {5'd0, cfg_i.init_three};
        entry_o.mask = rcrc_pkg::MASK_THREE;
      end
      default: begin
        // unknown kind: zero mask forces a zero crc
        entry_o.poly = '0;
        entry_o.init = '0;
        entry_o.mask = rcrc_pkg::MASK_NONE;
      end
    endcase
  end

endmodule

FILE: hw/rtl/rcrc_queue.sv
// ----------------------------------------------------------------------------
// rcrc_queue
// small fifo between the decode front and the crc engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rohc_crc3_crc7_crc8_check_core_assert.svh"

module rcrc_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  rcrc_pkg::entry_t wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output rcrc_pkg::entry_t rdata_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  rcrc_pkg::entry_t slots_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  assign full_o  = (count_q == FullCnt);
  assign valid_o = (count_q != '0);
  assign rdata_o = slots_q[rd_ptr_q];

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // slot storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= wdata_i;
    end
  end

  `RCRC_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= FullCnt)
  `RCRC_ASSERT_IMP(a_pop_nonempty, clk_i, rst_ni, pop_i, count_q != '0)
  `RCRC_ASSERT_NXT(a_count_up, clk_i, rst_ni, push_i && !pop_i,
                   count_q == $past(count_q) + 1'b1)

endmodule

FILE: hw/rtl/rcrc_back.sv
// ----------------------------------------------------------------------------
// rcrc_back
// crc engine with running value and registered result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rohc_crc3_crc7_crc8_check_core_assert.svh"

module rcrc_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             head_valid_i,
  input  rcrc_pkg::entry_t head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       crc_result_o,
  output logic             crc_match_o
);

  // one byte through the reflected crc, lsb first
  function automatic logic [rcrc_pkg::CrcW-1:0] mix_byte(
    input logic [rcrc_pkg::CrcW-1:0] seed,
    input logic [7:0]                data,
    input logic [rcrc_pkg::CrcW-1:0] poly
  );
    logic [rcrc_pkg::CrcW-1:0] v;
    v = seed ^ data;
    for (int k = 0; k < 8; k++) begin
      v = v[0] ? ((v >> 1) ^ poly) : (v >> 1);
    end
    return v;
  endfunction

  logic [rcrc_pkg::CrcW-1:0] running_q, running_d;
  logic [rcrc_pkg::CrcW-1:0] seed;
  logic [rcrc_pkg::CrcW-1:0] crc;
  logic                      out_valid_q, out_valid_d;
  logic [7:0]                result_q, result_d;
  logic                      match_q, match_d;
  logic                      can_take;

  assign can_take = !out_valid_q || out_ready_i;
  assign pop_o    = head_valid_i && (!head_i.last || can_take);

  // crc of the head byte
  assign seed = (head_i.first ? head_i.init : running_q) & head_i.mask;
  assign crc  = mix_byte(seed, head_i.data, head_i.poly) & head_i.mask;

  // running value and output slot
  always_comb begin
    running_d   = running_q;
    out_valid_d = out_valid_q;
    result_d    = result_q;
    match_d     = match_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (pop_o) begin
      running_d = crc;
      if (head_i.last) begin
        out_valid_d = 1'b1;
        result_d    = crc;
        match_d     = (crc == head_i.expected);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      running_q   <= running_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    result_q <= result_d;
    match_q  <= match_d;
  end

  assign out_valid_o  = out_valid_q;
  assign crc_result_o = result_q;
  assign crc_match_o  = match_q;

  `RCRC_ASSERT_IMP(a_last_has_slot, clk_i, rst_ni, pop_o && head_i.last, can_take)
  `RCRC_ASSERT_NXT(a_unknown_zero, clk_i, rst_ni,
                   pop_o && (head_i.mask == rcrc_pkg::MASK_NONE), running_q == '0)
  `RCRC_ASSERT_NXT(a_result_loaded, clk_i, rst_ni, pop_o && head_i.last,
                   out_valid_q && (result_q == running_q))

endmodule

FILE: hw/rtl/rohc_crc3_crc7_crc8_check_core.sv
// ----------------------------------------------------------------------------
// rohc_crc3_crc7_crc8_check_core
// rohc header crc-3 / crc-7 / crc-8 check with apb configuration
// ----------------------------------------------------------------------------
// Usage:
//   input channel (in_valid_i / in_ready_o) carries one covered header byte
//   per transfer with its crc kind, first and last flags and the expected
//   crc. A transfer with first set seeds the running crc from init_*.
//   output channel (out_valid_o / out_ready_i) carries one transfer per last
//   byte: the computed crc, zero extended, and a match flag.
//   a last byte passes the queue, then the engine registers its result.
//   throughput: one byte per cycle unless the engine stalls on a last byte;
//   the crc update is combinational. A queue of QUEUE_DEPTH entries sits
//   between decode and engine, so input keeps flowing while a result waits.
//   stall: when the receiver holds out_ready_i low the engine halts on the
//   next last byte, the queue fills and in_ready_o then drops.
//   reset: running crc clears to zero, queue and output empty, registers
//   return to the rfc 3095 polynomials and all-ones seeds. apb: registers at
//   byte address 4*index, written by the user only while idle (unchecked).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rohc_crc3_crc7_crc8_check_core #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // apb configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rcrc_pkg::AddrW-1:0]   paddr,
  input  logic [rcrc_pkg::DataW-1:0]   pwdata,
  output logic [rcrc_pkg::DataW-1:0]   prdata,
  output logic                         pready,
  // byte input
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   kind_i,
  input  logic [7:0]                   data_byte_i,
  input  logic                         first_byte_i,
  input  logic                         last_byte_i,
  input  logic [7:0]                   expected_crc_i,
  // result output
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [7:0]                   crc_result_o,
  output logic                         crc_match_o
);

  rcrc_pkg::cfg_t   cfg_q;
  logic [2:0]       reg_idx;
  logic             cfg_wr;
  logic             push;
  logic             full;
  logic             pop;
  logic             head_valid;
  rcrc_pkg::entry_t push_entry;
  rcrc_pkg::entry_t head_entry;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.poly_three <= rcrc_pkg::POLY_THREE_RST;
      cfg_q.poly_seven <= rcrc_pkg::POLY_SEVEN_RST;
      cfg_q.poly_eight <= rcrc_pkg::POLY_EIGHT_RST;
      cfg_q.init_three <= rcrc_pkg::INIT_THREE_RST;
      cfg_q.init_seven <= rcrc_pkg::INIT_SEVEN_RST;
      cfg_q.init_eight <= rcrc_pkg::INIT_EIGHT_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        rcrc_pkg::REG_POLY_THREE: cfg_q.poly_three <= pwdata[2:0];
        rcrc_pkg::REG_POLY_SEVEN: cfg_q.poly_seven <= pwdata[6:0];
        rcrc_pkg::REG_POLY_EIGHT: cfg_q.poly_eight <= pwdata[7:0];
        rcrc_pkg::REG_INIT_THREE: cfg_q.init_three <= pwdata[2:0];
        rcrc_pkg::REG_INIT_SEVEN: cfg_q.init_seven <= pwdata[6:0];
        rcrc_pkg::REG_INIT_EIGHT: cfg_q.init_eight <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (reg_idx)
      rcrc_pkg::REG_POLY_THREE: prdata = {29'd0, cfg_q.poly_three};
      rcrc_pkg::REG_POLY_SEVEN: prdata = {25'd0, cfg_q.poly_seven};
      rcrc_pkg::REG_POLY_EIGHT: prdata = {24'd0, cfg_q.poly_eight};
      rcrc_pkg::REG_INIT_THREE: prdata = {29'd0, cfg_q.init_three};
      rcrc_pkg::REG_INIT_SEVEN: prdata = {25'd0, cfg_q.init_seven};
      rcrc_pkg::REG_INIT_EIGHT: prdata = {24'd0, cfg_q.init_eight};
      default:                  prdata = '0;
    endcase
  end

  // decode front
  rcrc_front u_front (
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .kind_i         (kind_i),
    .data_byte_i    (data_byte_i),
    .first_byte_i   (first_byte_i),
    .last_byte_i    (last_byte_i),
    .expected_crc_i (expected_crc_i),
    .cfg_i          (cfg_q),
    .full_i         (full),
    .push_o         (push),
    .entry_o        (push_entry)
  );

  // decoupling queue
  rcrc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .rdata_o (head_entry)
  );

  // crc engine
  rcrc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head_entry),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .crc_result_o (crc_result_o),
    .crc_match_o  (crc_match_o)
  );

endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb - testbench for rohc_crc3_crc7_crc8_check_core
// Header bytes go in over a valid/ready channel with random bursts and gaps.
// Results are taken with a receiver that stalls on its own pattern. A
// tracker class follows the running crc and the register set, queues one
// verdict per last byte and checks each result transfer against the oldest
// one. Registers are written and read back over apb between phases, while
// the block is drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// running crc tracker: follows the block and holds the pending verdicts
class crc_tracker;
  typedef struct packed {
    logic [7:0] crc;
    logic       match;
  } verdict_t;

  logic [2:0] poly3;
  logic [6:0] poly7;
  logic [7:0] poly8;
  logic [2:0] init3;
  logic [6:0] init7;
  logic [7:0] init8;
  logic [7:0] run_crc;
  verdict_t   verdict_q[$];
  int         errors;

  function new();
    poly3   = rcrc_pkg::POLY_THREE_RST;
    poly7   = rcrc_pkg::POLY_SEVEN_RST;
    poly8   = rcrc_pkg::POLY_EIGHT_RST;
    init3   = rcrc_pkg::INIT_THREE_RST;
    init7   = rcrc_pkg::INIT_SEVEN_RST;
    init8   = rcrc_pkg::INIT_EIGHT_RST;
    run_crc = '0;
    errors  = 0;
  endfunction

  function void set_reg(logic [2:0] idx, logic [31:0] val);
    case (idx)
      rcrc_pkg::REG_POLY_THREE: poly3 = val[2:0];
      rcrc_pkg::REG_POLY_SEVEN: poly7 = val[6:0];
      rcrc_pkg::REG_POLY_EIGHT: poly8 = val[7:0];
      rcrc_pkg::REG_INIT_THREE: init3 = val[2:0];
      rcrc_pkg::REG_INIT_SEVEN: init7 = val[6:0];
      rcrc_pkg::REG_INIT_EIGHT: init8 = val[7:0];
      default: ;
    endcase
  endfunction

  function logic [31:0] reg_value(logic [2:0] idx);
    case (idx)
      rcrc_pkg::REG_POLY_THREE: return 32'(poly3);
      rcrc_pkg::REG_POLY_SEVEN: return 32'(poly7);
      rcrc_pkg::REG_POLY_EIGHT: return 32'(poly8);
      rcrc_pkg::REG_INIT_THREE: return 32'(init3);
      rcrc_pkg::REG_INIT_SEVEN: return 32'(init7);
      rcrc_pkg::REG_INIT_EIGHT: return 32'(init8);
      default: return '0;
    endcase
  endfunction

  // lsb-first update: xor the byte in, then eight reflected shifts
  function logic [7:0] shift_byte(logic [7:0] r, logic [7:0] b, logic [7:0] p);
    logic [7:0] v;
    v = r ^ b;
    for (int k = 0; k < 8; k++) begin
      v = v[0] ? ((v >> 1) ^ p) : (v >> 1);
    end
    return v;
  endfunction

  // one byte of the selected kind, returns the new running crc
  function logic [7:0] advance(rcrc_pkg::kind_e kind, logic [7:0] data, logic first);
    logic [7:0] base;
    logic [7:0] crc;
    case (kind)
      rcrc_pkg::KIND_CRC8: begin
        base = first ? init8 : run_crc;
        crc  = shift_byte(base, data, poly8);
      end
      rcrc_pkg::KIND_CRC7: begin
        base = (first ? {1'b0, init7} : run_crc) & rcrc_pkg::MASK_SEVEN;
        crc  = shift_byte(base, data, {1'b0, poly7}) & rcrc_pkg::MASK_SEVEN;
      end
      rcrc_pkg::KIND_CRC3: begin
        base = (first ? {5'b0, init3} : run_crc) & rcrc_pkg::MASK_THREE;
        crc  = shift_byte(base, data, {5'b0, poly3}) & rcrc_pkg::MASK_THREE;
      end
      default: crc = rcrc_pkg::MASK_NONE;
    endcase
    run_crc = crc;
    return crc;
  endfunction

  function void note_input(rcrc_pkg::kind_e kind, logic [7:0] data, logic first,
                           logic last, logic [7:0] expected);
    verdict_t v;
    v.crc   = advance(kind, data, first);
    v.match = (v.crc == expected);
    if (last) verdict_q.push_back(v);
  endfunction

  function void check_result(logic [7:0] crc, logic match);
    verdict_t v;
    if (verdict_q.size() == 0) begin
      fail($sformatf("result with nothing pending: crc %02h match %0b", crc, match));
      return;
    end
    v = verdict_q.pop_front();
    if (crc !== v.crc) fail($sformatf("crc_result exp %02h got %02h", v.crc, crc));
    if (match !== v.match) fail($sformatf("crc_match exp %0b got %0b", v.match, match));
  endfunction

  function void fail(string msg);
    errors++;
    if (errors <= 10) $display("mismatch: %s", msg);
  endfunction

  function int pending();
    return verdict_q.size();
  endfunction
endclass

module tb;

  typedef enum int {EXP_MATCH, EXP_RANDOM, EXP_FLIP, EXP_WIDE} exp_mode_e;
  typedef enum int {RDY_ALWAYS, RDY_MOSTLY, RDY_RARELY, RDY_PERIODIC} rdy_mode_e;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [rcrc_pkg::AddrW-1:0] paddr;
  logic [rcrc_pkg::DataW-1:0] pwdata;
  logic [rcrc_pkg::DataW-1:0] prdata;
  logic                       pready;
  logic                       in_valid_i;
  logic                       in_ready_o;
  logic [1:0]                 kind_i;
  logic [7:0]                 data_byte_i;
  logic                       first_byte_i;
  logic                       last_byte_i;
  logic [7:0]                 expected_crc_i;
  logic                       out_valid_o;
  logic                       out_ready_i;
  logic [7:0]                 crc_result_o;
  logic                       crc_match_o;

  // chk follows accepted transfers, gen_crc runs ahead for the stimulus
  crc_tracker chk     = new();
  crc_tracker gen_crc = new();

  bit        gaps_on;
  int        burst_left;
  rdy_mode_e rdy_mode;
  int        rdy_left;

  rohc_crc3_crc7_crc8_check_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .kind_i         (kind_i),
    .data_byte_i    (data_byte_i),
    .first_byte_i   (first_byte_i),
    .last_byte_i    (last_byte_i),
    .expected_crc_i (expected_crc_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .crc_result_o   (crc_result_o),
    .crc_match_o    (crc_match_o)
  );

  always #4 clk_i = ~clk_i;

  // monitor: note input transfers, check output transfers
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        chk.note_input(rcrc_pkg::kind_e'(kind_i), data_byte_i, first_byte_i,
                       last_byte_i, expected_crc_i);
      end
      if (out_valid_o && out_ready_i) chk.check_result(crc_result_o, crc_match_o);
    end
  end

  // receiver: segments of always ready, random, mostly stalled, periodic
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rdy_left = 0;
    end else begin
      if (rdy_left == 0) begin
        rdy_mode = rdy_mode_e'($urandom_range(0, 3));
        rdy_left = $urandom_range(16, 200);
      end
      rdy_left--;
      case (rdy_mode)
        RDY_ALWAYS: out_ready_i <= 1'b1;
        RDY_MOSTLY: out_ready_i <= ($urandom_range(0, 3) != 0);
        RDY_RARELY: out_ready_i <= ($urandom_range(0, 4) == 0);
        default:    out_ready_i <= ((rdy_left % 11) < 3);
      endcase
    end
  end

  // run limit
  initial begin
    #5_000_000;
    $display("[rohc_crc3_crc7_crc8_check_core] ERROR");
    $finish;
  end

  // one input transfer, with a random gap once a burst is used up and gaps are on
  task automatic send_item(rcrc_pkg::kind_e kind, logic [7:0] data, logic first,
                           logic last, logic [7:0] expected);
    if (gaps_on && burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = $urandom_range(1, 40);
    end
    if (burst_left > 0) burst_left--;
    in_valid_i     <= 1'b1;
    kind_i         <= kind;
    data_byte_i    <= data;
    first_byte_i   <= first;
    last_byte_i    <= last;
    expected_crc_i <= expected;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // choose the carried crc from the crc the byte will produce
  task automatic put_byte(rcrc_pkg::kind_e kind, logic [7:0] data, logic first,
                          logic last, exp_mode_e mode);
    logic [7:0] crc;
    logic [7:0] expv;
    crc = gen_crc.advance(kind, data, first);
    case (mode)
      EXP_MATCH:  expv = crc;
      EXP_RANDOM: expv = 8'($urandom());
      EXP_FLIP:   expv = crc ^ (8'h01 << $urandom_range(0, 7));
      default:    expv = crc ^ 8'h80;
    endcase
    send_item(kind, data, first, last, expv);
  endtask

  function automatic rcrc_pkg::kind_e pick_kind();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return rcrc_pkg::KIND_CRC8;
    if (r < 6) return rcrc_pkg::KIND_CRC7;
    if (r < 9) return rcrc_pkg::KIND_CRC3;
    return rcrc_pkg::KIND_UNKNOWN;
  endfunction

  function automatic exp_mode_e pick_mode();
    int r;
    r = $urandom_range(0, 5);
    if (r < 3) return EXP_MATCH;
    if (r == 3) return EXP_RANDOM;
    if (r == 4) return EXP_FLIP;
    return EXP_WIDE;
  endfunction

  // mostly framed messages, some with a kind change, the rest loose bytes
  task automatic random_message(output int n);
    rcrc_pkg::kind_e k;
    rcrc_pkg::kind_e kk;
    int              len;
    if ($urandom_range(0, 99) < 80) begin
      k   = pick_kind();
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
      for (int i = 0; i < len; i++) begin
        kk = ($urandom_range(0, 9) == 0) ? pick_kind() : k;
        put_byte(kk, 8'($urandom()), (i == 0), (i == len - 1), pick_mode());
      end
      n = len;
    end else begin
      put_byte(rcrc_pkg::kind_e'($urandom_range(0, 3)), 8'($urandom()), 1'($urandom()),
               1'($urandom()), pick_mode());
      n = 1;
    end
  endtask

  task automatic run_directed();
    // no first byte right after reset, continues from zero
    put_byte(rcrc_pkg::KIND_CRC8, 8'h00, 1'b0, 1'b1, EXP_MATCH);
    // one-byte messages at the data extremes
    put_byte(rcrc_pkg::KIND_CRC8, 8'hff, 1'b1, 1'b1, EXP_MATCH);
    put_byte(rcrc_pkg::KIND_CRC8, 8'h00, 1'b1, 1'b1, EXP_FLIP);
    put_byte(rcrc_pkg::KIND_CRC7, 8'h00, 1'b1, 1'b1, EXP_MATCH);
    put_byte(rcrc_pkg::KIND_CRC7, 8'hff, 1'b1, 1'b1, EXP_FLIP);
    put_byte(rcrc_pkg::KIND_CRC3, 8'h00, 1'b1, 1'b1, EXP_MATCH);
    put_byte(rcrc_pkg::KIND_CRC3, 8'hff, 1'b1, 1'b1, EXP_MATCH);
    // carried crc with high bits set never matches a narrow crc
    put_byte(rcrc_pkg::KIND_CRC3, 8'h5a, 1'b1, 1'b1, EXP_WIDE);
    put_byte(rcrc_pkg::KIND_CRC7, 8'ha5, 1'b1, 1'b1, EXP_WIDE);
    // unknown kind gives zero, then bytes continue from zero
    put_byte(rcrc_pkg::KIND_UNKNOWN, 8'h3c, 1'b1, 1'b1, EXP_MATCH);
    put_byte(rcrc_pkg::KIND_UNKNOWN, 8'hff, 1'b0, 1'b1, EXP_RANDOM);
    put_byte(rcrc_pkg::KIND_CRC8, 8'h12, 1'b0, 1'b0, EXP_MATCH);
    put_byte(rcrc_pkg::KIND_CRC8, 8'h34, 1'b0, 1'b1, EXP_MATCH);
    // three-byte messages
    put_byte(rcrc_pkg::KIND_CRC8, 8'h01, 1'b1, 1'b0, EXP_MATCH);
    put_byte(rcrc_pkg::KIND_CRC8, 8'h02, 1'b0, 1'b0, EXP_MATCH);
    put_byte(rcrc_pkg::KIND_CRC8, 8'h03, 1'b0, 1'b1, EXP_MATCH);
    put_byte(rcrc_pkg::KIND_CRC3, 8'hc3, 1'b1, 1'b0, EXP_MATCH);
    put_byte(rcrc_pkg::KIND_CRC3, 8'h3c, 1'b0, 1'b0, EXP_MATCH);
    put_byte(rcrc_pkg::KIND_CRC3, 8'h81, 1'b0, 1'b1, EXP_RANDOM);
    // kind changes inside one message
    put_byte(rcrc_pkg::KIND_CRC8, 8'haa, 1'b1, 1'b0, EXP_MATCH);
    put_byte(rcrc_pkg::KIND_CRC7, 8'h55, 1'b0, 1'b0, EXP_MATCH);
    put_byte(rcrc_pkg::KIND_CRC3, 8'h0f, 1'b0, 1'b1, EXP_MATCH);
    // byte after a last byte without first
    put_byte(rcrc_pkg::KIND_CRC7, 8'h80, 1'b0, 1'b1, EXP_MATCH);
  endtask

  // stop input and wait until every verdict has been taken
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (chk.pending() > 0) @(negedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic apb_access(logic wr, logic [rcrc_pkg::AddrW-1:0] addr,
                            logic [rcrc_pkg::DataW-1:0] wdata,
                            output logic [rcrc_pkg::DataW-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
  endtask

  // write all six registers with junk above their width, then read back
  task automatic load_config(logic [7:0] vals [6]);
    logic [rcrc_pkg::DataW-1:0] rd;
    logic [rcrc_pkg::DataW-1:0] wd;
    logic [31:0]                byte_addr;
    for (int i = 0; i < 6; i++) begin
      wd        = {24'($urandom()), vals[i]};
      byte_addr = 32'(i * 4);
      apb_access(1'b1, byte_addr[rcrc_pkg::AddrW-1:0], wd, rd);
      chk.set_reg(3'(i), wd);
      gen_crc.set_reg(3'(i), wd);
    end
    for (int i = 0; i < 6; i++) begin
      byte_addr = 32'(i * 4);
      apb_access(1'b0, byte_addr[rcrc_pkg::AddrW-1:0], '0, rd);
      if (rd !== chk.reg_value(3'(i))) begin
        chk.fail($sformatf("register %0d read exp %08h got %08h", i,
                           chk.reg_value(3'(i)), rd));
      end
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    int         count;
    int         n;
    logic [7:0] vals [6];
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_valid_i     = 1'b0;
    kind_i         = '0;
    data_byte_i    = '0;
    first_byte_i   = 1'b0;
    last_byte_i    = 1'b0;
    expected_crc_i = '0;
    gaps_on        = 1'b1;
    burst_left     = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    wait_drained();

    // register settings: zeros, ones, random ones, then the defaults again
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: vals = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        1: vals = '{8'h07, 8'h7f, 8'hff, 8'h07, 8'h7f, 8'hff};
        6: vals = '{8'(rcrc_pkg::POLY_THREE_RST),
                    8'(rcrc_pkg::POLY_SEVEN_RST),
                    rcrc_pkg::POLY_EIGHT_RST,
                    8'(rcrc_pkg::INIT_THREE_RST),
                    8'(rcrc_pkg::INIT_SEVEN_RST),
                    rcrc_pkg::INIT_EIGHT_RST};
        default: begin
          for (int i = 0; i < 6; i++) vals[i] = 8'($urandom());
        end
      endcase
      load_config(vals);
      gaps_on    = ($urandom_range(0, 3) != 0);
      burst_left = 0;
      count      = 0;
      while (count < 115) begin
        random_message(n);
        count += n;
      end
      wait_drained();
    end

    repeat (16) @(posedge clk_i);
    if (chk.errors == 0 && chk.pending() == 0) begin
      $display("[rohc_crc3_crc7_crc8_check_core] OK");
    end else begin
      $display("[rohc_crc3_crc7_crc8_check_core] ERROR");
    end
    $finish;
  end
endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/rcrc_pkg.sv
hw/rtl/rcrc_front.sv
hw/rtl/rcrc_queue.sv
hw/rtl/rcrc_back.sv
hw/rtl/rohc_crc3_crc7_crc8_check_core.sv
test/tb.sv
